// ===== rtl/nrr_pkg.sv =====
// Package for the notification response reassembler.
// Holds the codes, the parser state, configuration and result structs and the limits.
// No dependencies.
`timescale 1ns / 1ps

package nrr_pkg;

  // Largest number of attribute headers a reply may carry.
  localparam int MAX_ATTRIBUTES = 8;

  localparam int CNT_W = 17;
  localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};

  // Input operations.
  typedef enum logic [1:0] {
    OP_DATA  = 2'd0,
    OP_ARM   = 2'd1,
    OP_ABORT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Result events.
  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_UID    = 3'd1,
    EV_APPID  = 3'd2,
    EV_HEADER = 3'd3,
    EV_VALUE  = 3'd4
  } event_t;

  // Fragment status.
  typedef enum logic [1:0] {
    STAT_MID      = 2'd0,
    STAT_NEED     = 2'd1,
    STAT_COMPLETE = 2'd2,
    STAT_ERROR    = 2'd3
  } status_t;

  // Error codes.
  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_REQ    = 3'd1,
    ERR_OVERSIZE  = 3'd2,
    ERR_NO_ECHO   = 3'd3,
    ERR_BAD_CMD   = 3'd4,
    ERR_ORDER     = 3'd5,
    ERR_LENGTH    = 3'd6,
    ERR_TRAILING  = 3'd7
  } err_t;

  // Parse phases.
  typedef enum logic [2:0] {
    PH_ECHO   = 3'd0,
    PH_UID    = 3'd1,
    PH_APPID  = 3'd2,
    PH_HEADER = 3'd3,
    PH_VALUE  = 3'd4
  } phase_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_REPLY_COMMAND = 3'd0;
  localparam logic [2:0] REG_ATTR_ID_LIST  = 3'd1;
  localparam logic [2:0] REG_ATTR_COUNT    = 3'd2;
  localparam logic [2:0] REG_MAX_ATTR_LEN  = 3'd3;
  localparam logic [2:0] REG_MAX_RESP      = 3'd4;

  // Command values that the echo may carry.
  localparam logic [7:0] CMD_NOTIF_ATTRS = 8'd0;
  localparam logic [7:0] CMD_APP_ATTRS   = 8'd1;

  typedef struct packed {
    logic [7:0]  reply_command;
    logic [63:0] attribute_id_list;
    logic [3:0]  attribute_count;
    logic [15:0] attr_len_limit;
    logic [15:0] reply_size_limit;
  } cfg_t;

  typedef struct packed {
    logic             request_active;
    logic             fragment_unrequested;
    phase_t           parse_phase;
    logic [CNT_W-1:0] bytes_received;
    logic [1:0]       field_position;
    logic [31:0]      uid_shift;
    logic [3:0]       attribute_index;
    logic [15:0]      value_remaining;
    logic [7:0]       current_id;
    err_t             latched_error;
    logic             reply_finished;
  } state_t;

  typedef struct packed {
    event_t      event_res;
    logic [7:0]  data_byte;
    logic [31:0] uid;
    logic [7:0]  attribute_id;
    logic [15:0] attribute_length;
    status_t     status;
    err_t        error_code;
  } result_t;

endpackage

// ===== rtl/nrr_step.sv =====
// Next-state and result logic for one transfer of the reply parser.
// Depends on nrr_pkg for the state, configuration and result types.
`timescale 1ns / 1ps

module nrr_step import nrr_pkg::*; (
  input  state_t     st,
  input  cfg_t       cfg,
  input  op_t        op,
  input  logic [7:0] byte_value,
  input  logic       last_of_fragment,
  output state_t     st_nxt,
  output result_t    res
);

  logic [3:0]       exp_cnt;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      len;
  logic [7:0]       want_id;
  logic [15:0]      rem;
  logic             go_next;

  // Expected header count, saturated at the table size.
  assign exp_cnt = (cfg.attribute_count > 4'(MAX_ATTRIBUTES)) ?
                   4'(MAX_ATTRIBUTES) : cfg.attribute_count;

  assign len     = {byte_value, st.value_remaining[7:0]};
  assign want_id = cfg.attribute_id_list[{st.attribute_index[2:0], 3'b000} +: 8];
  assign rem     = (st.value_remaining != 16'd0) ? st.value_remaining - 16'd1 : 16'd0;

  always_comb begin
    st_nxt  = st;
    res     = '0;
    cnt     = st.bytes_received;
    go_next = 1'b0;

    unique case (op)
      OP_ARM: begin
        st_nxt = '0;
        st_nxt.request_active = 1'b1;
      end
      OP_ABORT: begin
        st_nxt = '0;
      end
      OP_DATA: begin
        if (!st.request_active) begin
          st_nxt.fragment_unrequested = 1'b1;
        end else begin
          // Saturating byte count; the size check overrides any other error.
          if (st.bytes_received != CNT_SAT) cnt = st.bytes_received + 1'b1;
          st_nxt.bytes_received = cnt;
          if (cnt > {1'b0, cfg.reply_size_limit}) begin
            st_nxt.latched_error = ERR_OVERSIZE;
          end else if (st.latched_error == ERR_NONE) begin
            if (st.reply_finished) begin
              st_nxt.latched_error = ERR_TRAILING;
            end else begin
              case (st.parse_phase)
                PH_ECHO: begin
                  if (byte_value != cfg.reply_command) begin
                    st_nxt.latched_error = ERR_NO_ECHO;
                  end else if (byte_value == CMD_NOTIF_ATTRS) begin
                    st_nxt.parse_phase    = PH_UID;
                    st_nxt.field_position = 2'd0;
                    st_nxt.uid_shift      = 32'd0;
                  end else if (byte_value == CMD_APP_ATTRS) begin
                    st_nxt.parse_phase = PH_APPID;
                  end else begin
                    st_nxt.latched_error = ERR_BAD_CMD;
                  end
                end
                PH_UID: begin
                  st_nxt.uid_shift = st.uid_shift |
                                     (32'(byte_value) << {st.field_position, 3'b000});
                  if (st.field_position == 2'd3) begin
                    res.event_res = EV_UID;
                    res.uid       = st_nxt.uid_shift;
                    go_next       = 1'b1;
                  end else begin
                    st_nxt.field_position = st.field_position + 2'd1;
                  end
                end
                PH_APPID: begin
                  // The terminating NUL ends the app id without an event.
                  if (byte_value == 8'd0) begin
                    go_next = 1'b1;
                  end else begin
                    res.event_res = EV_APPID;
                    res.data_byte = byte_value;
                  end
                end
                PH_HEADER: begin
                  if (st.field_position == 2'd0) begin
                    st_nxt.current_id     = byte_value;
                    st_nxt.field_position = 2'd1;
                  end else if (st.field_position == 2'd1) begin
                    st_nxt.value_remaining = {8'd0, byte_value};
                    st_nxt.field_position  = 2'd2;
                  end else if (st.current_id != want_id) begin
                    st_nxt.latched_error = ERR_ORDER;
                  end else if (len > cfg.attr_len_limit) begin
                    st_nxt.latched_error = ERR_LENGTH;
                  end else begin
                    res.event_res          = EV_HEADER;
                    res.attribute_id       = st.current_id;
                    res.attribute_length   = len;
                    st_nxt.attribute_index = st.attribute_index + 4'd1;
                    st_nxt.value_remaining = len;
                    st_nxt.field_position  = 2'd0;
                    if (len == 16'd0) begin
                      go_next = 1'b1;
                    end else begin
                      st_nxt.parse_phase = PH_VALUE;
                    end
                  end
                end
                default: begin
                  res.event_res          = EV_VALUE;
                  res.data_byte          = byte_value;
                  res.attribute_id       = st.current_id;
                  st_nxt.value_remaining = rem;
                  if (rem == 16'd0) go_next = 1'b1;
                end
              endcase

              // Move on to the next header, or finish the reply.
              if (go_next) begin
                if (st_nxt.attribute_index >= exp_cnt) begin
                  st_nxt.reply_finished = 1'b1;
                end else begin
                  st_nxt.parse_phase    = PH_HEADER;
                  st_nxt.field_position = 2'd0;
                end
              end
            end
          end
        end

        // Fragment end reports the reply status.
        if (last_of_fragment) begin
          if (st_nxt.fragment_unrequested) begin
            res.status                  = STAT_ERROR;
            res.error_code              = ERR_NO_REQ;
            st_nxt.fragment_unrequested = 1'b0;
          end else if (st_nxt.latched_error != ERR_NONE) begin
            res.status     = STAT_ERROR;
            res.error_code = st_nxt.latched_error;
            st_nxt         = '0;
          end else if (st_nxt.reply_finished) begin
            res.status = STAT_COMPLETE;
            st_nxt     = '0;
          end else begin
            res.status = STAT_NEED;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/notification_response_reassembler.sv =====
// Top level of the notification response reassembler: configuration
// registers, parser state and the result register. Uses nrr_pkg and nrr_step.
//
//  channel | direction | handshake         | payload
//  in_     | input     | in_valid/in_stall | operation, byte_value, last_of_fragment
//  out_    | output    | out_valid/out_stall | event_res ... error_code
//  cfg_    | input     | cfg_we            | cfg_index, cfg_data
//
// One transfer per cycle while in_stall is low: the step logic parses each input
// transfer combinationally and it lands in the result register on the same edge.
// The result register frees on the edge its transfer completes, so a new
// input transfer is taken in that same cycle; in_stall is high only while a
// result waits under out_stall. Reset (synchronous, active low) clears the
// parser state and loads the configuration reset values.
`timescale 1ns / 1ps

module notification_response_reassembler import nrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_of_fragment,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_data_byte,
  output logic [31:0] out_uid,
  output logic [7:0]  out_attribute_id,
  output logic [15:0] out_attribute_length,
  output logic [1:0]  out_status,
  output logic [2:0]  out_error_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    in_take;

  assign in_stall = out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  nrr_step u_step (
    .st               (st_r),
    .cfg              (cfg_r),
    .op               (op_t'(in_operation)),
    .byte_value       (in_byte_value),
    .last_of_fragment (in_last_of_fragment),
    .st_nxt           (st_nxt),
    .res              (res_nxt)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reply_command     <= 8'd0;
      cfg_r.attribute_id_list <= 64'd0;
      cfg_r.attribute_count   <= 4'd0;
      cfg_r.attr_len_limit    <= 16'd512;
      cfg_r.reply_size_limit  <= 16'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPLY_COMMAND: cfg_r.reply_command     <= cfg_data[7:0];
        REG_ATTR_ID_LIST:  cfg_r.attribute_id_list <= cfg_data;
        REG_ATTR_COUNT:    cfg_r.attribute_count   <= cfg_data[3:0];
        REG_MAX_ATTR_LEN:  cfg_r.attr_len_limit    <= cfg_data[15:0];
        REG_MAX_RESP:      cfg_r.reply_size_limit  <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Parser state advances on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_take) begin
      st_r <= st_nxt;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) res_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_event_res        = res_r.event_res;
  assign out_data_byte        = res_r.data_byte;
  assign out_uid              = res_r.uid;
  assign out_attribute_id     = res_r.attribute_id;
  assign out_attribute_length = res_r.attribute_length;
  assign out_status           = res_r.status;
  assign out_error_code       = res_r.error_code;

`ifndef SYNTHESIS
  // An accepted input always yields a result on the next cycle.
  a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> out_valid_r)
    else $error("input transfer produced no result");

  // Error status and a nonzero error code go together.
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((res_r.status == STAT_ERROR) == (res_r.error_code != ERR_NONE)))
    else $error("error status and error code disagree");

  // No bytes are counted without an active request.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.request_active |-> (st_r.bytes_received == '0))
    else $error("byte count nonzero with no request");

  // The header index never passes the table size.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.attribute_index <= 4'(MAX_ATTRIBUTES))
    else $error("attribute index out of range");
`endif

endmodule
